// ----- hdl/mrle_pkg.sv -----
// Shared types and constants of the marker RLE run decoder.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package mrle_pkg;

	// Largest decoded size, as a power of two
	localparam int SIZE_BITS = 24;

	// Fixed field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W = 16;
	localparam int ADDR_W = 32;
	localparam int CFG_SIZE_W = 25;
	localparam int PEND_W = 15;

	// Produced-byte counter holds up to 2^SIZE_BITS
	localparam int CNT_W = SIZE_BITS + 1;
	// Width for size compares: wide enough for the counter and the register
	localparam int CMP_W = (CNT_W > CFG_SIZE_W) ? CNT_W : CFG_SIZE_W;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_DEST_BASE = 1'b0;
	localparam logic REG_DEST_SIZE = 1'b1;

	// Parser phases
	localparam logic [2:0] PH_MARKER = 3'd0;
	localparam logic [2:0] PH_SYMBOL = 3'd1;
	localparam logic [2:0] PH_COUNT = 3'd2;
	localparam logic [2:0] PH_COUNT_LO = 3'd3;
	localparam logic [2:0] PH_RUN_SYM = 3'd4;

	// Count codes
	localparam logic [BYTE_W-1:0] SHORT_COUNT_MAX = 8'd2;
	localparam logic [BYTE_W-1:0] COUNT_LO_MASK = 8'h7f;

	typedef struct packed {
		logic [ADDR_W-1:0]     dest_base;
		logic [CFG_SIZE_W-1:0] dest_size;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] run_value;
		logic [LEN_W-1:0]  run_length;
		logic [ADDR_W-1:0] dest_address;
		logic              done_res;
	} res_t;

endpackage

`default_nettype wire

// ----- hdl/mrle_in_if.sv -----
// Compressed byte channel: valid/ready handshake with byte and stream start.
// Depends on mrle_pkg for field widths.
`default_nettype none

interface mrle_in_if;
	logic                         valid;
	logic                         ready;
	logic [mrle_pkg::BYTE_W-1:0]  data_byte;
	logic                         stream_start;

	modport source (output valid, output data_byte, output stream_start, input ready);
	modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

`default_nettype wire

// ----- hdl/mrle_out_if.sv -----
// Decoded run channel: valid/ready handshake with one run per transfer.
// Depends on mrle_pkg for field widths.
`default_nettype none

interface mrle_out_if;
	logic                         valid;
	logic                         ready;
	logic [mrle_pkg::BYTE_W-1:0]  run_value;
	logic [mrle_pkg::LEN_W-1:0]   run_length;
	logic [mrle_pkg::ADDR_W-1:0]  dest_address;
	logic                         done_res;

	modport source (output valid, output run_value, output run_length,
		output dest_address, output done_res, input ready);
	modport sink (input valid, input run_value, input run_length,
		input dest_address, input done_res, output ready);
endinterface

`default_nettype wire

// ----- hdl/mrle_cfg_regs.sv -----
// APB-style register file: destination base address and decoded size.
// Depends on mrle_pkg.
`default_nettype none

module mrle_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mrle_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [mrle_pkg::PDATA_W-1:0]  pwdata,
	output logic      [mrle_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output mrle_pkg::cfg_t                     cfg
);
	import mrle_pkg::*;

	logic [ADDR_W-1:0]     dest_base_q;
	logic [CFG_SIZE_W-1:0] dest_size_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	// Write on the access phase; register index sits in address bit 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_base_q <= '0;
			dest_size_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DEST_BASE: dest_base_q <= pwdata[ADDR_W-1:0];
				REG_DEST_SIZE: dest_size_q <= pwdata[CFG_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			REG_DEST_BASE: prdata = PDATA_W'(dest_base_q);
			REG_DEST_SIZE: prdata = PDATA_W'(dest_size_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.dest_base = dest_base_q;
	assign cfg.dest_size = dest_size_q;

endmodule

`default_nettype wire

// ----- hdl/mrle_parser.sv -----
// Byte parser: marker/count/symbol phases, run clipping and address tracking.
// Holds the stream state; depends on mrle_pkg.
`default_nettype none

module mrle_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [mrle_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                          stream_start,
	input  mrle_pkg::cfg_t                     cfg,
	output logic                               res_valid,
	output mrle_pkg::res_t                     res
);
	import mrle_pkg::*;

	localparam logic [CMP_W-1:0] SIZE_CAP = CMP_W'(1) << SIZE_BITS;

	logic [2:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] marker_q, marker_d;
	logic [PEND_W-1:0] pend_q, pend_d;
	logic [CNT_W-1:0]  produced_q, produced_d;
	logic              finished_q, finished_d;

	logic [CMP_W-1:0]  size_ext;
	logic [CMP_W-1:0]  limit;
	logic [CMP_W-1:0]  produced_ext;
	logic [CMP_W-1:0]  remain;
	logic              emit;
	logic [BYTE_W-1:0] emit_value;
	logic [LEN_W-1:0]  emit_reps;
	logic              clip;
	logic [LEN_W-1:0]  emit_len;

	// Size limit and what remains of it
	assign size_ext = CMP_W'(cfg.dest_size);
	assign limit = (size_ext < SIZE_CAP) ? size_ext : SIZE_CAP;
	assign produced_ext = CMP_W'(produced_q);
	assign remain = limit - produced_ext;

	// Clip the run to the remaining size
	assign clip = CMP_W'(emit_reps) >= remain;
	assign emit_len = clip ? remain[LEN_W-1:0] : emit_reps;

	// Next state and run request
	always_comb begin
		phase_d = phase_q;
		marker_d = marker_q;
		pend_d = pend_q;
		produced_d = produced_q;
		finished_d = finished_q;
		emit = 1'b0;
		emit_value = data_byte;
		emit_reps = LEN_W'(1);

		if (stream_start || phase_q == PH_MARKER || phase_q > PH_RUN_SYM) begin
			marker_d = data_byte;
			pend_d = '0;
			produced_d = '0;
			finished_d = 1'b0;
			phase_d = PH_SYMBOL;
		end else if (finished_q) begin
			// drop bytes after done
		end else if (produced_ext >= limit) begin
			finished_d = 1'b1;
		end else begin
			unique case (phase_q)
				PH_SYMBOL: begin
					if (data_byte == marker_q) begin
						phase_d = PH_COUNT;
					end else begin
						emit = 1'b1;
					end
				end
				PH_COUNT: begin
					if (data_byte <= SHORT_COUNT_MAX) begin
						phase_d = PH_SYMBOL;
						emit = 1'b1;
						emit_value = marker_q;
						emit_reps = LEN_W'(data_byte) + LEN_W'(1);
					end else if (data_byte[BYTE_W-1]) begin
						pend_d = {data_byte[BYTE_W-2:0], {BYTE_W{1'b0}}};
						phase_d = PH_COUNT_LO;
					end else begin
						pend_d = PEND_W'(data_byte);
						phase_d = PH_RUN_SYM;
					end
				end
				PH_COUNT_LO: begin
					pend_d = pend_q | PEND_W'(data_byte);
					phase_d = PH_RUN_SYM;
				end
				PH_RUN_SYM: begin
					phase_d = PH_SYMBOL;
					emit = 1'b1;
					emit_reps = LEN_W'(pend_q) + LEN_W'(1);
				end
				default: ;
			endcase
			if (emit) begin
				produced_d = produced_q + CNT_W'(emit_len);
				finished_d = clip;
			end
		end
	end

	// Advance the state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARKER;
			marker_q <= '0;
			pend_q <= '0;
			produced_q <= '0;
			finished_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			marker_q <= marker_d;
			pend_q <= pend_d;
			produced_q <= produced_d;
			finished_q <= finished_d;
		end
	end

	assign res_valid = step && emit;
	assign res.run_value = emit_value;
	assign res.run_length = emit_len;
	assign res.dest_address = cfg.dest_base + ADDR_W'(produced_q);
	assign res.done_res = clip;

	// A run always carries at least one byte
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.run_length != '0)
		else $error("run of zero length");

	// A clipped run ends the stream
	a_done_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.done_res) |=> finished_q)
		else $error("done run did not finish the stream");

	// The produced count never passes the size cap
	a_produced_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(produced_q) <= SIZE_CAP)
		else $error("produced count beyond size cap");

	// Nothing is emitted once the stream is finished, short of a new stream
	a_quiet_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(step && finished_q && !stream_start && phase_q != PH_MARKER) |-> !res_valid)
		else $error("run emitted after done");

endmodule

`default_nettype wire

// ----- hdl/marker_rle_run_decoder_unit.sv -----
// Marker RLE run decoder takes one compressed byte per cycle and returns one
// run per cycle at most. An accepted byte is held in an input register until
// the result side frees up, parsed against the stream state, and the run it
// finishes (if any) is loaded into the result register, from which it is
// offered on the output. The parser updates its state once per processed
// byte: a new byte is accepted every cycle while the result register is
// empty or being read. Configure dest_base (offset 0x0) and dest_size
// (offset 0x4) only while no byte is in flight.
// Depends on mrle_pkg, mrle_in_if, mrle_out_if, mrle_cfg_regs, mrle_parser.
`default_nettype none

module marker_rle_run_decoder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mrle_in_if.sink                            cmp,
	mrle_out_if.source                         run,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mrle_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [mrle_pkg::PDATA_W-1:0]  pwdata,
	output logic      [mrle_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);
	import mrle_pkg::*;

	cfg_t              cfg;
	res_t              res;
	logic              res_valid;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;
	logic              advance;
	logic              step;
	logic              in_xfer;

	logic              out_valid_q;
	res_t              out_q;

	mrle_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline moves when the result register can take a new entry
	assign advance = !out_valid_q || run.ready;
	assign step = valid_s1 && advance;
	assign cmp.ready = !valid_s1 || advance;
	assign in_xfer = cmp.valid && cmp.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmp.ready) begin
			valid_s1 <= cmp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= cmp.data_byte;
			start_s1 <= cmp.stream_start;
		end
	end

	mrle_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (byte_s1),
		.stream_start (start_s1),
		.cfg          (cfg),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign run.valid = out_valid_q;
	assign run.run_value = out_q.run_value;
	assign run.run_length = out_q.run_length;
	assign run.dest_address = out_q.dest_address;
	assign run.done_res = out_q.done_res;

	// A held input byte is processed as soon as the result side frees up
	a_step_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |-> step)
		else $error("held byte not processed with free result register");

	// A byte in the input register stays until processed
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register lost a byte");

	// A parsed run lands in the result register
	a_run_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid_q)
		else $error("parsed run not loaded");

endmodule

`default_nettype wire

// ----- bench/mrle_run_checker.sv -----
`timescale 1ns / 100ps
// Run checker for the marker RLE run decoder: watches the byte, run and
// register channels, predicts each run and compares it field by field.
// Depends on mrle_pkg, mrle_in_if and mrle_out_if.

module mrle_run_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	mrle_in_if                            cmp,
	mrle_out_if                           run,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mrle_pkg::PADDR_W-1:0]  paddr,
	input  logic [mrle_pkg::PDATA_W-1:0]  pwdata,
	input  logic [mrle_pkg::PDATA_W-1:0]  prdata,
	input  logic                          pready,
	output int unsigned                   fail_count,
	output int unsigned                   runs_pending
);
	import mrle_pkg::*;

	localparam logic [CMP_W-1:0] SIZE_CAP = CMP_W'(1) << SIZE_BITS;

	// Register copies
	logic [ADDR_W-1:0]     cfg_base;
	logic [CFG_SIZE_W-1:0] cfg_size;

	// Parser copy
	logic [2:0]        parse_state;
	logic [BYTE_W-1:0] marker_byte;
	logic [PEND_W-1:0] pend_count;
	logic [CMP_W-1:0]  out_bytes;
	logic              stream_done;

	// Runs predicted but not yet seen
	res_t run_q[$];
	res_t want;
	logic [PDATA_W-1:0] reg_want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_val);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
		fail_count++;
	endtask

	// Advance the parser copy by one byte; return 1 when the byte ends a run
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic s,
		output res_t r);
		logic [CMP_W-1:0] lim;
		logic [CMP_W-1:0] remain;
		logic [CMP_W-1:0] reps;
		logic [BYTE_W-1:0] value;
		bit hit;
		r = '0;
		hit = 1'b0;
		reps = CMP_W'(1);
		value = b;
		// new stream: the byte is the marker
		if (s || parse_state == PH_MARKER || parse_state > PH_RUN_SYM) begin
			marker_byte = b;
			pend_count = '0;
			out_bytes = '0;
			stream_done = 1'b0;
			parse_state = PH_SYMBOL;
			return 1'b0;
		end
		if (stream_done)
			return 1'b0;
		lim = (CMP_W'(cfg_size) < SIZE_CAP) ? CMP_W'(cfg_size) : SIZE_CAP;
		if (out_bytes >= lim) begin
			stream_done = 1'b1;
			return 1'b0;
		end
		case (parse_state)
			PH_SYMBOL: begin
				if (b == marker_byte)
					parse_state = PH_COUNT;
				else
					hit = 1'b1;
			end
			PH_COUNT: begin
				if (b <= SHORT_COUNT_MAX) begin
					// marker itself repeated
					parse_state = PH_SYMBOL;
					value = marker_byte;
					reps = CMP_W'(b) + CMP_W'(1);
					hit = 1'b1;
				end else if (b[BYTE_W-1]) begin
					pend_count = PEND_W'({b & COUNT_LO_MASK, 8'h00});
					parse_state = PH_COUNT_LO;
				end else begin
					pend_count = PEND_W'(b);
					parse_state = PH_RUN_SYM;
				end
			end
			PH_COUNT_LO: begin
				pend_count = pend_count | PEND_W'(b);
				parse_state = PH_RUN_SYM;
			end
			default: begin
				// symbol of a counted run
				parse_state = PH_SYMBOL;
				reps = CMP_W'(pend_count) + CMP_W'(1);
				hit = 1'b1;
			end
		endcase
		if (hit) begin
			remain = lim - out_bytes;
			r.run_value = value;
			r.done_res = 1'b0;
			if (reps >= remain) begin
				reps = remain;
				r.done_res = 1'b1;
				stream_done = 1'b1;
			end
			r.run_length = LEN_W'(reps);
			r.dest_address = cfg_base + ADDR_W'(out_bytes);
			out_bytes = out_bytes + reps;
		end
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_base = '0;
			cfg_size = '0;
			parse_state = PH_MARKER;
			marker_byte = '0;
			pend_count = '0;
			out_bytes = '0;
			stream_done = 1'b0;
			run_q.delete();
			fail_count = 0;
			runs_pending <= 0;
		end else begin
			// register access completes
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_DEST_BASE)
						cfg_base = pwdata;
					else
						cfg_size = CFG_SIZE_W'(pwdata);
				end else begin
					reg_want = (paddr[2] == REG_DEST_BASE) ? cfg_base : PDATA_W'(cfg_size);
					if (prdata !== reg_want)
						report_mismatch("register read", prdata, reg_want);
				end
			end

			// retire one run against the oldest prediction
			if (run.valid && run.ready) begin
				if (run_q.size() == 0) begin
					report_mismatch("run with none expected", run.dest_address, '0);
				end else begin
					want = run_q.pop_front();
					if (run.run_value !== want.run_value)
						report_mismatch("run_value", 32'(run.run_value),
							32'(want.run_value));
					if (run.run_length !== want.run_length)
						report_mismatch("run_length", 32'(run.run_length),
							32'(want.run_length));
					if (run.dest_address !== want.dest_address)
						report_mismatch("dest_address", run.dest_address, want.dest_address);
					if (run.done_res !== want.done_res)
						report_mismatch("done_res", 32'(run.done_res),
							32'(want.done_res));
				end
			end

			// predict from each byte transfer
			if (cmp.valid && cmp.ready) begin
				if (decode_byte(cmp.data_byte, cmp.stream_start, want))
					run_q.push_back(want);
			end

			runs_pending <= run_q.size();
		end
	end

endmodule

// ----- bench/marker_rle_run_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the marker RLE run decoder bench: clock, reset, byte streams, run
// pacing, register writes and the verdict.
// Depends on mrle_pkg, mrle_in_if, mrle_out_if, mrle_run_checker and the block.

module marker_rle_run_decoder_unit_tb;
	import mrle_pkg::*;

	localparam int IDLE_HEAVY = 81;
	localparam int IDLE_MIX = 26;
	localparam int MAX_GAP = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT = 20000;
	localparam int PHASE_BYTES = 75;
	localparam int NUM_PHASES = 8;
	// about 750 bytes at worst pacing stay far below this
	localparam int LIMIT_NS = 2000000;

	localparam logic [PADDR_W-1:0] ADDR_DEST_BASE = {REG_DEST_BASE, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_DEST_SIZE = {REG_DEST_SIZE, 2'b00};
	localparam logic [PDATA_W-1:0] SIZE_FULL = PDATA_W'(1) << SIZE_BITS;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned fail_count;
	int unsigned runs_pending;

	// pacing controls
	int tx_idle_pct;
	int rx_stall_pct;
	bit rx_hold;
	int hold_cnt;
	int bytes_sent;

	mrle_in_if  cmp_if();
	mrle_out_if run_if();

	marker_rle_run_decoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmp     (cmp_if),
		.run     (run_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mrle_run_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmp          (cmp_if),
		.run          (run_if),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.runs_pending (runs_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run receiver: random stalls, or a long hold-off counted here
	always @(posedge clk) begin
		if (!arst_n) begin
			run_if.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (rx_hold && hold_cnt < HOLD_CYCLES) begin
			run_if.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			if (!rx_hold)
				hold_cnt <= 0;
			run_if.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Stop a hung run
	initial begin
		#LIMIT_NS;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return BYTE_W'($urandom);
	endfunction

	// Offer one byte after a random gap; valid stays high on return
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic s);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			cmp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmp_if.valid <= 1'b1;
		cmp_if.data_byte <= b;
		cmp_if.stream_start <= s;
		do
			@(posedge clk);
		while (!cmp_if.ready);
		bytes_sent++;
	endtask

	// Drop valid and hold until every predicted run has been taken
	task automatic wait_idle();
		int guard;
		guard = 0;
		cmp_if.valid <= 1'b0;
		@(posedge clk);
		while (runs_pending != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register transfer; psel stays high for a following transfer
	task automatic reg_access(input bit wr, input logic [PADDR_W-1:0] a,
		input logic [PDATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
	endtask

	task automatic reg_release();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write both registers and read them back
	task automatic set_config(input logic [PDATA_W-1:0] base, input logic [PDATA_W-1:0] size);
		reg_access(1'b1, ADDR_DEST_BASE, base);
		reg_access(1'b1, ADDR_DEST_SIZE, size);
		reg_access(1'b0, ADDR_DEST_BASE, '0);
		reg_access(1'b0, ADDR_DEST_SIZE, '0);
		reg_release();
	endtask

	task automatic write_size(input logic [PDATA_W-1:0] size);
		reg_access(1'b1, ADDR_DEST_SIZE, size);
		reg_release();
	endtask

	task automatic set_pacing(input int tx, input int rx, input bit hold);
		tx_idle_pct = tx;
		rx_stall_pct <= rx;
		rx_hold <= hold;
	endtask

	// One stream: marker, then literal, short, counted and long runs with some noise
	task automatic send_stream(input int tokens);
		logic [BYTE_W-1:0] mark;
		logic [BYTE_W-1:0] sym;
		logic [PEND_W-1:0] cnt;
		int kind;
		mark = pick_byte();
		push_byte(mark, 1'b1);
		repeat (tokens) begin
			kind = $urandom_range(99);
			sym = pick_byte();
			if (kind < 40) begin
				if (sym == mark)
					sym = ~mark;
				push_byte(sym, 1'b0);
			end else if (kind < 55) begin
				push_byte(mark, 1'b0);
				push_byte(BYTE_W'($urandom_range(SHORT_COUNT_MAX)), 1'b0);
			end else if (kind < 75) begin
				push_byte(mark, 1'b0);
				push_byte(BYTE_W'($urandom_range(127, SHORT_COUNT_MAX + 1)), 1'b0);
				push_byte(sym, 1'b0);
			end else if (kind < 90) begin
				if ($urandom_range(99) < 70)
					cnt = PEND_W'($urandom_range(300));
				else
					cnt = PEND_W'($urandom);
				push_byte(mark, 1'b0);
				push_byte({1'b1, cnt[14:8]}, 1'b0);
				push_byte(cnt[7:0], 1'b0);
				push_byte(sym, 1'b0);
			end else if (kind < 97) begin
				// stray byte, may open an escape out of step
				push_byte(pick_byte(), 1'b0);
			end else begin
				// restart mid-stream with a fresh marker
				mark = pick_byte();
				push_byte(mark, 1'b1);
			end
		end
	endtask

	initial begin
		int target;
		bit paused;
		arst_n = 1'b0;
		cmp_if.valid = 1'b0;
		cmp_if.data_byte = '0;
		cmp_if.stream_start = 1'b0;
		run_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold = 1'b0;
		bytes_sent = 0;
		paused = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: size above the cap, addresses wrapping past the top
		set_config(32'hFFFF_FF00, 32'hFFFF_FFFF);
		// marker taken without a stream start after reset
		push_byte(8'h5A, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(SHORT_COUNT_MAX, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(SHORT_COUNT_MAX + 8'd1, 1'b0);
		push_byte(8'h77, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(COUNT_LO_MASK, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h33, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		// new stream in the middle of a long count
		push_byte(8'h5A, 1'b0);
		push_byte(8'h85, 1'b0);
		push_byte(8'hC3, 1'b1);
		push_byte(8'hC3, 1'b0);
		push_byte(8'h01, 1'b0);
		wait_idle();

		// Directed: size zero, then finished streams and clipping
		set_config(32'h0000_0000, 32'h0000_0000);
		push_byte(8'h10, 1'b1);
		push_byte(8'h20, 1'b0);
		wait_idle();
		write_size(32'd5);
		push_byte(8'h30, 1'b0);
		push_byte(8'h10, 1'b1);
		push_byte(8'h10, 1'b0);
		push_byte(8'h07, 1'b0);
		push_byte(8'h44, 1'b0);
		push_byte(8'h01, 1'b0);

		// Random phases, each with its own settings and pacing
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					set_config($urandom, SIZE_FULL);
					set_pacing(0, 0, 1'b0);
				end
				1: begin
					set_config(32'hFFFF_FFFF, 32'h01FF_FFFF);
					set_pacing(IDLE_HEAVY, 0, 1'b0);
				end
				2: begin
					set_config($urandom, $urandom_range(2000, 1));
					set_pacing(0, IDLE_HEAVY, 1'b0);
				end
				3: begin
					set_config(32'h0000_0000, $urandom_range(1 << 20, 1));
					set_pacing(IDLE_MIX, IDLE_MIX, 1'b0);
				end
				4: begin
					// receiver holds off while bytes keep coming
					set_config($urandom, SIZE_FULL);
					set_pacing(0, 0, 1'b1);
				end
				5: begin
					set_config($urandom, 32'd1);
					set_pacing(IDLE_MIX, 0, 1'b0);
				end
				6: begin
					set_config($urandom, $urandom_range(32'h01FF_FFFF, 1));
					set_pacing(IDLE_MIX, IDLE_MIX, 1'b0);
				end
				default: begin
					// size lowered under the produced count mid-stream
					set_config($urandom, 32'd1000);
					set_pacing(0, IDLE_HEAVY, 1'b0);
					push_byte(8'h3C, 1'b1);
					push_byte(8'h01, 1'b0);
					push_byte(8'h02, 1'b0);
					wait_idle();
					write_size(32'd1);
					push_byte(8'h05, 1'b0);
					wait_idle();
					write_size(32'd1000);
					push_byte(8'h06, 1'b0);
				end
			endcase
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				send_stream(ph == 5 ? $urandom_range(2, 1) : $urandom_range(20, 4));
				// pause the sender once until all runs are out
				if (ph == 6 && !paused && bytes_sent > target - PHASE_BYTES / 2) begin
					wait_idle();
					paused = 1'b1;
				end
			end
		end
		wait_idle();

		if (fail_count == 0 && runs_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mrle_pkg.sv
hdl/mrle_in_if.sv
hdl/mrle_out_if.sv
hdl/mrle_cfg_regs.sv
hdl/mrle_parser.sv
hdl/marker_rle_run_decoder_unit.sv
bench/mrle_run_checker.sv
bench/marker_rle_run_decoder_unit_tb.sv
